/* src/ldp_pkg.sv */
// Shared types, constants and register indexes for the landing phase detector.
`default_nettype none
package ldp_pkg;

	localparam int WINDOW_LEN_DEF = 10;
	localparam int ALT_W          = 24;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RISE_STEP    = 3'd0,
		REG_FALL_STEP    = 3'd1,
		REG_RISE_CNT     = 3'd2,
		REG_FALL_CNT     = 3'd3,
		REG_INVALID_ALT  = 3'd4,
		REG_FALL_CEILING = 3'd5,
		REG_GROUND_VAR   = 3'd6
	} cfg_reg_t;

	localparam logic [1:0] VERDICT_FLYING  = 2'd0;
	localparam logic [1:0] VERDICT_RELEASE = 2'd1;
	localparam logic [1:0] VERDICT_GROUND  = 2'd2;

	localparam logic [15:0] RISE_STEP_RST    = 16'd50;
	localparam logic [15:0] FALL_STEP_RST    = 16'd40;
	localparam logic [4:0]  RISE_CNT_RST     = 5'd3;
	localparam logic [4:0]  FALL_CNT_RST     = 5'd3;
	localparam logic [22:0] INVALID_ALT_RST  = 23'd3000000;
	localparam logic [22:0] FALL_CEILING_RST = 23'd1000000;
	localparam logic [23:0] GROUND_VAR_RST   = 24'd60000;

	typedef struct packed {
		logic signed [ALT_W-1:0] altitude_mm;
		logic                    free_fall;
	} in_req_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic       rise_flag;
		logic       fall_flag;
	} out_req_t;

	// control from the sequencer to the statistics unit
	typedef struct packed {
		logic clear;
		logic take;
		logic first;
		logic mul;
	} ldp_ctl_t;

endpackage
`default_nettype wire

/* src/landing_phase_detector.sv */
// Top level: window cell chain, sequencer, configuration registers, result register.
// A request is taken only in idle: the sequencer walks the window, then steps through
// the SQ, MUL and DONE states and returns to idle once the result is registered;
// the window is rotated once through the statistics unit, one cell per cycle.
// A result still waiting in the output register holds the next one in the sequencer.
// Reset: window cleared to zero, flags cleared, registers at their reset values.
`default_nettype none
module landing_phase_detector #(
	parameter int WINDOW_LEN = ldp_pkg::WINDOW_LEN_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire ldp_pkg::in_req_t                   in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output ldp_pkg::out_req_t                       out_data,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [ldp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ldp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CW = $clog2(WINDOW_LEN);
	localparam int AW = ldp_pkg::ALT_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_WALK = 5'b00010,
		ST_SQ   = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic              ff_q, rise_q, fall_q, out_valid_q;
	ldp_pkg::out_req_t out_q;

	logic [15:0] rise_step_q, fall_step_q;
	logic [4:0]  rise_cnt_q, fall_cnt_q;
	logic [22:0] invalid_alt_q, fall_ceiling_q;
	logic [23:0] ground_var_q;

	logic                  accept, load, shift, finish;
	logic signed [AW-1:0]  cell_q [WINDOW_LEN];
	logic signed [AW-1:0]  feed;
	ldp_pkg::ldp_ctl_t     ctl;
	logic [CW-1:0]         ups, downs;
	logic signed [AW-1:0]  oldest;
	logic                  flat;

	logic       old_inv, old_ceil, rise_hit, fall_hit;
	logic       rise_n, fall_n;
	logic [1:0] verdict_n;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign load      = accept;
	assign shift     = load || (state_q == ST_WALK);
	assign feed      = load ? in_data.altitude_mm : cell_q[0];
	assign finish    = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_LEN; gi++) begin : g_cell
			if (gi == WINDOW_LEN - 1) begin : g_tail
				ldp_cell u_cell (
					.clk   (clk),
					.arst_n(arst_n),
					.shift (shift),
					.d     (feed),
					.q     (cell_q[gi])
				);
			end else begin : g_body
				ldp_cell u_cell (
					.clk   (clk),
					.arst_n(arst_n),
					.shift (shift),
					.d     (cell_q[gi+1]),
					.q     (cell_q[gi])
				);
			end
		end
	endgenerate

	always_comb begin
		ctl.clear = accept;
		ctl.take  = (state_q == ST_WALK);
		ctl.first = (cnt_q == '0);
		ctl.mul   = (state_q == ST_MUL);
	end

	ldp_stats #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.head      (cell_q[0]),
		.rise_step (rise_step_q),
		.fall_step (fall_step_q),
		.ground_var(ground_var_q),
		.ups       (ups),
		.downs     (downs),
		.oldest    (oldest),
		.flat      (flat)
	);

	assign old_inv  = $signed({oldest[AW-1], oldest}) >= $signed({2'b00, invalid_alt_q});
	assign old_ceil = $signed({oldest[AW-1], oldest}) >= $signed({2'b00, fall_ceiling_q});
	assign rise_hit = 32'(ups) >= 32'(rise_cnt_q);
	assign fall_hit = (32'(downs) >= 32'(fall_cnt_q)) || ff_q;

	always_comb begin
		rise_n    = rise_q;
		fall_n    = fall_q;
		verdict_n = ldp_pkg::VERDICT_FLYING;
		if (!rise_q && old_inv) begin
			verdict_n = ldp_pkg::VERDICT_FLYING;
		end else begin
			if (!rise_q && rise_hit) begin
				rise_n = 1'b1;
			end
			if (rise_n && !fall_q) begin
				if (!old_ceil && fall_hit) begin
					fall_n    = 1'b1;
					verdict_n = ldp_pkg::VERDICT_RELEASE;
				end
			end else if (rise_n && fall_q && flat) begin
				verdict_n = ldp_pkg::VERDICT_GROUND;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rise_q      <= 1'b0;
			fall_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WALK;
						cnt_q   <= '0;
					end
				end
				ST_WALK: begin
					if (cnt_q == CW'(WINDOW_LEN - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SQ;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQ: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (finish) begin
						rise_q  <= rise_n;
						fall_q  <= fall_n;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ff_q <= in_data.free_fall;
		end
		if (finish) begin
			out_q.verdict   <= verdict_n;
			out_q.rise_flag <= rise_n;
			out_q.fall_flag <= fall_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_step_q    <= ldp_pkg::RISE_STEP_RST;
			fall_step_q    <= ldp_pkg::FALL_STEP_RST;
			rise_cnt_q     <= ldp_pkg::RISE_CNT_RST;
			fall_cnt_q     <= ldp_pkg::FALL_CNT_RST;
			invalid_alt_q  <= ldp_pkg::INVALID_ALT_RST;
			fall_ceiling_q <= ldp_pkg::FALL_CEILING_RST;
			ground_var_q   <= ldp_pkg::GROUND_VAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ldp_pkg::REG_RISE_STEP:    rise_step_q    <= cfg_data[15:0];
				ldp_pkg::REG_FALL_STEP:    fall_step_q    <= cfg_data[15:0];
				ldp_pkg::REG_RISE_CNT:     rise_cnt_q     <= cfg_data[4:0];
				ldp_pkg::REG_FALL_CNT:     fall_cnt_q     <= cfg_data[4:0];
				ldp_pkg::REG_INVALID_ALT:  invalid_alt_q  <= cfg_data[22:0];
				ldp_pkg::REG_FALL_CEILING: fall_ceiling_q <= cfg_data[22:0];
				ldp_pkg::REG_GROUND_VAR:   ground_var_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_WALK))
		else $error("request accept did not start the window walk");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid_q)
		else $error("finished request produced no result");

	a_fall_needs_rise: assert property (@(posedge clk) disable iff (!arst_n)
		fall_q |-> rise_q)
		else $error("descent flagged without ascent");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_WALK) |-> (cnt_q == '0))
		else $error("walk counter left nonzero outside the walk");

endmodule
`default_nettype wire

/* src/ldp_cell.sv */
// One window cell: holds a sample and passes it to its neighbor on shift.
`default_nettype none
module ldp_cell (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              shift,
	input  wire logic signed [ldp_pkg::ALT_W-1:0]  d,
	output logic signed [ldp_pkg::ALT_W-1:0]       q
);

	logic signed [ldp_pkg::ALT_W-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule
`default_nettype wire

/* src/ldp_stats.sv */
// Step counts, sums and variance test over the samples walked out of the window.
`default_nettype none
module ldp_stats #(
	parameter int WINDOW_LEN = ldp_pkg::WINDOW_LEN_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire ldp_pkg::ldp_ctl_t                     ctl,
	input  wire logic signed [ldp_pkg::ALT_W-1:0]      head,
	input  wire logic [15:0]                           rise_step,
	input  wire logic [15:0]                           fall_step,
	input  wire logic [23:0]                           ground_var,
	output logic [$clog2(WINDOW_LEN)-1:0]              ups,
	output logic [$clog2(WINDOW_LEN)-1:0]              downs,
	output logic signed [ldp_pkg::ALT_W-1:0]           oldest,
	output logic                                       flat
);

	localparam int CW      = $clog2(WINDOW_LEN);
	localparam int SUM_W   = ldp_pkg::ALT_W + CW;
	localparam int SQ_W    = 2 * ldp_pkg::ALT_W - 1;
	localparam int SUMSQ_W = SQ_W + CW;
	localparam int CMP_W   = 2 * SUM_W + 2;
	localparam int DIF_W   = ldp_pkg::ALT_W + 1;

	logic [CW-1:0]                     ups_q, downs_q;
	logic signed [ldp_pkg::ALT_W-1:0]  prev_q, old_q;
	logic signed [SUM_W-1:0]           sum_q;
	logic [SUMSQ_W-1:0]                sumsq_q;
	logic [SQ_W-1:0]                   sq_s1;
	logic                              sq_v_s1;
	logic [CMP_W-1:0]                  sum2_q, nsq_q, lim_q;

	logic signed [DIF_W-1:0]           d_up, d_down, up_thr, down_thr;
	logic signed [2*ldp_pkg::ALT_W-1:0] head_sq;
	logic signed [2*SUM_W-1:0]         sum_x, sum_sq;
	logic [CMP_W-1:0]                  spread;

	assign d_up     = DIF_W'(head) - DIF_W'(prev_q);
	assign d_down   = DIF_W'(prev_q) - DIF_W'(head);
	assign up_thr   = $signed({{(DIF_W-16){1'b0}}, rise_step});
	assign down_thr = $signed({{(DIF_W-16){1'b0}}, fall_step});
	assign head_sq  = (2*ldp_pkg::ALT_W)'(head) * (2*ldp_pkg::ALT_W)'(head);
	assign sum_x    = (2*SUM_W)'(sum_q);
	assign sum_sq   = sum_x * sum_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ups_q   <= '0;
			downs_q <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			sq_v_s1 <= 1'b0;
		end else if (ctl.clear) begin
			ups_q   <= '0;
			downs_q <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			sq_v_s1 <= 1'b0;
		end else begin
			sq_v_s1 <= ctl.take;
			if (sq_v_s1) begin
				sumsq_q <= sumsq_q + SUMSQ_W'(sq_s1);
			end
			if (ctl.take) begin
				sum_q <= sum_q + SUM_W'(head);
				if (!ctl.first) begin
					if (d_up > up_thr) begin
						ups_q <= ups_q + 1'b1;
					end
					if (d_down > down_thr) begin
						downs_q <= downs_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			sq_s1  <= head_sq[SQ_W-1:0];
			prev_q <= head;
			if (ctl.first) begin
				old_q <= head;
			end
		end
		if (ctl.mul) begin
			sum2_q <= CMP_W'($unsigned(sum_sq));
			nsq_q  <= CMP_W'(sumsq_q) * CMP_W'(WINDOW_LEN);
			lim_q  <= CMP_W'(ground_var) * CMP_W'(WINDOW_LEN * WINDOW_LEN);
		end
	end

	assign spread = nsq_q - sum2_q;
	assign flat   = spread < lim_q;
	assign ups    = ups_q;
	assign downs  = downs_q;
	assign oldest = old_q;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for landing_phase_detector: flight-phase prediction, random traffic and stalls.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ldp_pkg::*;

	localparam int WL = WINDOW_LEN_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam longint ALT_MAX = 8388607;
	localparam longint ALT_MIN = -8388608;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	typedef logic signed [ALT_W-1:0] alt_t;
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
	} reg_write_t;

	class verdict_scoreboard;
		alt_t        alt_hist [WL];
		bit          ascent_seen;
		bit          descent_seen;
		bit [15:0]   rise_step;
		bit [15:0]   fall_step;
		bit [4:0]    rise_cnt;
		bit [4:0]    fall_cnt;
		bit [22:0]   invalid_alt;
		bit [22:0]   fall_ceiling;
		bit [23:0]   ground_var;
		out_req_t    expected_verdicts [$];
		int          errors;
		int          n_req;
		int          n_res;
		int          n_cfg;
		int          n_release;
		int          n_ground;

		function new();
			foreach (alt_hist[i]) alt_hist[i] = '0;
			ascent_seen  = 1'b0;
			descent_seen = 1'b0;
			rise_step    = RISE_STEP_RST;
			fall_step    = FALL_STEP_RST;
			rise_cnt     = RISE_CNT_RST;
			fall_cnt     = FALL_CNT_RST;
			invalid_alt  = INVALID_ALT_RST;
			fall_ceiling = FALL_CEILING_RST;
			ground_var   = GROUND_VAR_RST;
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			n_cfg++;
			case (idx)
				REG_RISE_STEP:    rise_step = val[15:0];
				REG_FALL_STEP:    fall_step = val[15:0];
				REG_RISE_CNT:     rise_cnt = val[4:0];
				REG_FALL_CNT:     fall_cnt = val[4:0];
				REG_INVALID_ALT:  invalid_alt = val[22:0];
				REG_FALL_CEILING: fall_ceiling = val[22:0];
				REG_GROUND_VAR:   ground_var = val[23:0];
				default: ;
			endcase
		endfunction

		function out_req_t predict_verdict(in_req_t r, bit commit);
			alt_t     w [WL];
			bit       up_seen;
			bit       dn_seen;
			bit       settled;
			int       ups;
			int       downs;
			longint   x;
			longint   sum;
			longint   sumsq;
			out_req_t res;
			w = alt_hist;
			for (int i = 0; i < WL - 1; i++) w[i] = w[i+1];
			w[WL-1] = r.altitude_mm;
			up_seen = ascent_seen;
			dn_seen = descent_seen;
			settled = 1'b0;
			ups = 0;
			downs = 0;
			sum = 0;
			sumsq = 0;
			res.verdict = VERDICT_FLYING;
			if (!up_seen) begin
				if (longint'(w[0]) >= longint'(invalid_alt)) begin
					settled = 1'b1;
				end else begin
					for (int i = 1; i < WL; i++)
						if (longint'(w[i]) - longint'(w[i-1]) > longint'(rise_step)) ups++;
					if (ups >= rise_cnt) up_seen = 1'b1;
				end
			end
			if (!settled && up_seen && !dn_seen) begin
				if (longint'(w[0]) >= longint'(fall_ceiling)) begin
					settled = 1'b1;
				end else begin
					for (int i = 1; i < WL; i++)
						if (longint'(w[i-1]) - longint'(w[i]) > longint'(fall_step)) downs++;
					if (downs >= fall_cnt || r.free_fall) begin
						dn_seen = 1'b1;
						res.verdict = VERDICT_RELEASE;
						settled = 1'b1;
					end
				end
			end
			if (!settled && up_seen && dn_seen) begin
				for (int i = 0; i < WL; i++) begin
					x = longint'(w[i]);
					sum += x;
					sumsq += x * x;
				end
				if (WL * sumsq - sum * sum < longint'(ground_var) * WL * WL)
					res.verdict = VERDICT_GROUND;
			end
			res.rise_flag = up_seen;
			res.fall_flag = dn_seen;
			if (commit) begin
				alt_hist = w;
				ascent_seen = up_seen;
				descent_seen = dn_seen;
			end
			return res;
		endfunction

		function void note_request(in_req_t r);
			expected_verdicts.push_back(predict_verdict(r, 1'b1));
			n_req++;
		endfunction

		function void check_result(out_req_t got);
			out_req_t want;
			if (expected_verdicts.size() == 0) begin
				$error("result with no request pending: verdict %0d", got.verdict);
				errors++;
				return;
			end
			want = expected_verdicts.pop_front();
			n_res++;
			if (got.verdict !== want.verdict) begin
				$error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
				errors++;
			end
			if (got.rise_flag !== want.rise_flag) begin
				$error("rise_flag: expected %0d, got %0d", want.rise_flag, got.rise_flag);
				errors++;
			end
			if (got.fall_flag !== want.fall_flag) begin
				$error("fall_flag: expected %0d, got %0d", want.fall_flag, got.fall_flag);
				errors++;
			end
			if (want.verdict == VERDICT_RELEASE) n_release++;
			if (want.verdict == VERDICT_GROUND) n_ground++;
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_req_t               in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_req_t              out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	verdict_scoreboard sb = new();
	reg_write_t        staged_regs [$];
	int                tx_idle_pct = 0;
	int                rx_stall_pct = 0;
	int                seg_left = 0;
	int                seg_kind = 0;
	longint            seg_level = 0;
	longint            seg_gap = 0;
	longint            seg_amp = 0;
	bit                seg_phase = 1'b0;

	longint directed_alt [0:21] = '{8388607, -8388608, -1, -1, -1, -1, -1, -1, -1, -1,
		0, 3000000, 2999999, 2999999, 2999999, 2999999, 2999999, 2999999, 2999999,
		2999999, 2999999, 2999999};

	landing_phase_detector u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			sb.check_result(out_data);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
					(cfg_valid && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
		$display("landing_phase_detector verification failed");
		$finish;
	end

	function automatic alt_t clamp_alt(longint v);
		if (v > ALT_MAX) return alt_t'(ALT_MAX);
		if (v < ALT_MIN) return alt_t'(ALT_MIN);
		return alt_t'(v);
	endfunction

	function automatic void set_idle(idle_mode_t mode);
		case (mode)
			IDLE_SENDER:   begin tx_idle_pct = 55; rx_stall_pct = 0; end
			IDLE_RECEIVER: begin tx_idle_pct = 0; rx_stall_pct = 55; end
			IDLE_BOTH:     begin tx_idle_pct = 35; rx_stall_pct = 35; end
			default:       begin tx_idle_pct = 0; rx_stall_pct = 0; end
		endcase
	endfunction

	function automatic void stage_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		reg_write_t w;
		w.idx = idx;
		w.val = val;
		staged_regs.push_back(w);
	endfunction

	// segments of flat, alternating, extreme or wild samples once both phases are done
	function automatic longint landed_sample();
		logic [ALT_W-1:0] raw;
		if (seg_left == 0) begin
			seg_left = $urandom_range(6, 16);
			seg_kind = $urandom_range(0, 4);
			seg_level = longint'($urandom_range(0, 2000000)) - 1000000;
			seg_gap = $urandom_range(0, 4);
			case ($urandom_range(0, 4))
				0: seg_amp = 0;
				1: seg_amp = 60;
				2: seg_amp = 300;
				3: seg_amp = 450;
				default: seg_amp = 3000;
			endcase
			if (seg_kind == 3) seg_level = $urandom_range(0, 1) ? ALT_MAX : ALT_MIN;
			if (seg_kind == 2 && $urandom_range(0, 5) == 0) begin
				seg_level = ALT_MIN;
				seg_gap = ALT_MAX - ALT_MIN;
			end
		end
		seg_left--;
		seg_phase = !seg_phase;
		raw = ALT_W'($urandom());
		case (seg_kind)
			2: return seg_level + (seg_phase ? seg_gap : 64'sd0);
			3: return seg_level;
			4: return longint'($signed(raw));
			default: return seg_level + longint'($urandom_range(0, 2 * seg_amp)) - seg_amp;
		endcase
	endfunction

	function automatic in_req_t next_sample(bit allow_shift);
		in_req_t          r;
		out_req_t         probe;
		logic [ALT_W-1:0] raw;
		longint           v;
		longint           newest;
		longint           stp;
		longint           lim;
		newest = sb.alt_hist[WL-1];
		r.free_fall = 1'($urandom_range(0, 1));
		raw = ALT_W'($urandom());
		if (sb.ascent_seen && sb.descent_seen) begin
			v = landed_sample();
		end else if (allow_shift && !sb.ascent_seen) begin
			r.free_fall = ($urandom_range(0, 19) == 0);
			if (newest > 4000000 || newest < -4000000)
				v = $urandom_range(0, 5000);
			else
				v = newest + longint'(sb.rise_step) + 1 + $urandom_range(0, 300);
		end else if (allow_shift) begin
			r.free_fall = ($urandom_range(0, 7) == 0);
			if (newest > 4000000 || newest < -4000000)
				v = 500000;
			else
				v = newest - longint'(sb.fall_step) - 1 - $urandom_range(0, 300);
		end else begin
			stp = sb.ascent_seen ? longint'(sb.fall_step) : longint'(sb.rise_step);
			lim = sb.ascent_seen ? longint'(sb.fall_ceiling) : longint'(sb.invalid_alt);
			case ($urandom_range(0, 9))
				0, 1: v = longint'($signed(raw));
				2, 3, 4, 5: v = newest + ($urandom_range(0, 1) ? 1 : -1) *
					(stp + $urandom_range(0, 2) - 1);
				6, 7: v = lim + $urandom_range(0, 2) - 1;
				default: v = longint'($urandom_range(0, 200000)) - 100000;
			endcase
		end
		r.altitude_mm = clamp_alt(v);
		// keep the current phase unless this stretch is meant to move on
		if (!allow_shift && !(sb.ascent_seen && sb.descent_seen)) begin
			probe = sb.predict_verdict(r, 1'b0);
			if (probe.rise_flag != sb.ascent_seen || probe.fall_flag != sb.descent_seen) begin
				r.altitude_mm = sb.alt_hist[WL-1];
				r.free_fall = 1'b0;
			end
		end
		return r;
	endfunction

	task automatic send_sample(in_req_t r);
		int gap;
		gap = 0;
		while (gap < 30 && $urandom_range(0, 99) < tx_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_request(r);
	endtask

	task automatic await_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic commit_regs();
		foreach (staged_regs[k]) begin
			cfg_index <= staged_regs[k].idx;
			cfg_data <= staged_regs[k].val;
			cfg_valid <= 1'b1;
			do @(posedge clk); while (cfg_ready !== 1'b1);
			sb.configure(staged_regs[k].idx, staged_regs[k].val);
		end
		cfg_valid <= 1'b0;
		staged_regs.delete();
	endtask

	task automatic run_phase(idle_mode_t mode, int count, bit allow_shift);
		bit      rise0;
		bit      fall0;
		in_req_t r;
		set_idle(mode);
		rise0 = sb.ascent_seen;
		fall0 = sb.descent_seen;
		for (int n = 0; n < count; n++) begin
			r = next_sample(allow_shift);
			send_sample(r);
			if (allow_shift && (sb.ascent_seen != rise0 || sb.descent_seen != fall0)) break;
			if ($urandom_range(0, 99) == 0) await_results();
		end
		await_results();
	endtask

	initial begin
		in_req_t r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset register values: field extremes, invalid limit hit exactly and missed by one
		set_idle(IDLE_NONE);
		for (int i = 0; i < 22; i++) begin
			r.altitude_mm = clamp_alt(directed_alt[i]);
			r.free_fall = i[0];
			send_sample(r);
		end
		await_results();

		// before ascent
		stage_reg(REG_RISE_CNT, 24'd31);
		stage_reg(REG_RISE_STEP, 24'd0);
		stage_reg(REG_INVALID_ALT, 24'd0);
		stage_reg(REG_UNMAPPED, 24'($urandom()));
		commit_regs();
		run_phase(IDLE_SENDER, 70, 1'b0);
		stage_reg(REG_RISE_CNT, 24'hABCDEA);
		stage_reg(REG_RISE_STEP, 24'hFFFFFF);
		stage_reg(REG_INVALID_ALT, 24'hFFFFFF);
		commit_regs();
		run_phase(IDLE_RECEIVER, 70, 1'b0);
		stage_reg(REG_RISE_CNT, 24'($urandom_range(3, 9)));
		stage_reg(REG_RISE_STEP, 24'($urandom_range(0, 2000)));
		stage_reg(REG_INVALID_ALT, 24'($urandom()));
		commit_regs();
		run_phase(IDLE_BOTH, 70, 1'b0);

		// climb until ascent is marked; a zero count minimum marks it at once
		stage_reg(REG_INVALID_ALT, 24'h7FFFFF);
		stage_reg(REG_RISE_STEP, 24'($urandom_range(0, 1000)));
		stage_reg(REG_RISE_CNT, 24'hFFFFE0 | 24'($urandom_range(0, 9)));
		commit_regs();
		run_phase(IDLE_NONE, 40, 1'b1);

		// after ascent, before descent
		run_phase(IDLE_BOTH, 60, 1'b0);
		stage_reg(REG_FALL_CEILING, 24'd0);
		stage_reg(REG_FALL_STEP, 24'd0);
		stage_reg(REG_FALL_CNT, 24'd31);
		commit_regs();
		run_phase(IDLE_RECEIVER, 60, 1'b0);
		stage_reg(REG_FALL_CEILING, 24'hFFFFFF);
		stage_reg(REG_FALL_STEP, 24'hFFFFFF);
		stage_reg(REG_FALL_CNT, 24'($urandom_range(3, 9)));
		commit_regs();
		run_phase(IDLE_NONE, 60, 1'b0);

		// descend until release
		stage_reg(REG_FALL_CEILING, 24'h7FFFFF);
		stage_reg(REG_FALL_STEP, 24'($urandom_range(0, 1000)));
		stage_reg(REG_FALL_CNT, 24'($urandom_range(0, 9)));
		commit_regs();
		run_phase(IDLE_SENDER, 40, 1'b1);

		// on the ground: variance against several thresholds
		run_phase(IDLE_BOTH, 55, 1'b0);
		stage_reg(REG_GROUND_VAR, 24'd0);
		commit_regs();
		run_phase(IDLE_NONE, 55, 1'b0);
		stage_reg(REG_GROUND_VAR, 24'hFFFFFF);
		commit_regs();
		run_phase(IDLE_SENDER, 55, 1'b0);
		stage_reg(REG_GROUND_VAR, 24'($urandom_range(1, 4)));
		commit_regs();
		run_phase(IDLE_RECEIVER, 55, 1'b0);
		stage_reg(REG_GROUND_VAR, 24'($urandom_range(0, 200000)));
		commit_regs();
		run_phase(IDLE_BOTH, 55, 1'b0);

		set_idle(IDLE_NONE);
		repeat (3 * (WL + 4)) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d results never arrived", sb.pending());
			sb.errors++;
		end
		$display("Sent %0d altitude samples through ascent, descent and landing",
			sb.n_req);
		$display("with %0d register writes.", sb.n_cfg);
		$display("Checked %0d verdicts: %0d release, %0d ground, %0d mismatches.",
			sb.n_res, sb.n_release, sb.n_ground, sb.errors);
		if (sb.errors == 0)
			$display("landing_phase_detector verification clean");
		else
			$display("landing_phase_detector verification failed");
		$finish;
	end

endmodule

/* filelist.f */
src/ldp_pkg.sv
src/ldp_cell.sv
src/ldp_stats.sv
src/landing_phase_detector.sv
tb/tb_top.sv
